### hw/rtl/awb_otp_gain_calc_unit_macros.svh
// Assertion macros for the white balance gain calculation unit.
`ifndef AWB_OTP_GAIN_CALC_UNIT_MACROS_SVH
`define AWB_OTP_GAIN_CALC_UNIT_MACROS_SVH

// Assert an implication on every clock edge outside reset.
`define AWB_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Assert an implication whose consequent is checked in the cycle after the antecedent.
`define AWB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### hw/rtl/awb_pkg.sv
// Shared types and constants of the white balance gain calculation unit.
package awb_pkg;
   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_ZERO = 2'd1;
   localparam logic [1:0] STATUS_RND  = 2'd2;
   localparam logic [15:0] UNITY_GAIN  = 16'h0100;
   localparam logic [15:0] UNITY_RATIO = 16'd512;
   localparam logic [15:0] MAX16       = 16'hFFFF;

   // Work item between front and back: operands of the division sequence.
   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] golden_red;
      logic [15:0] golden_blue;
      logic [15:0] meas_red;
      logic [15:0] meas_blue;
   } item_type;

   // Result item.
   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] red_gain;
      logic [15:0] green_gain;
      logic [15:0] blue_gain;
   } result_type;
endpackage

### hw/rtl/awb_divider.sv
// Iterative restoring divider, one quotient bit a cycle, saturated 16-bit quotient.
module awb_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [27:0] dividend,
   input  logic [16:0] divisor,
   output logic        done,
   output logic [15:0] quotient
);
   import awb_pkg::*;

   logic [4:0]  count_ff, count_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [27:0] quo_ff, quo_in;
   logic [27:0] rem_ff, rem_in;
   logic [16:0] div_ff, div_in;
   logic [28:0] trial;
   logic [27:0] shifted;

   // Shift one dividend bit into the partial remainder and try a subtract.
   always_comb begin
      shifted = {rem_ff[26:0], quo_ff[27]};
      trial   = {1'b0, shifted} - {12'd0, div_ff};
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = 5'd0;
         quo_in   = dividend;
         rem_in   = 28'd0;
         div_in   = divisor;
      end else if (busy_ff) begin
         if (trial[28]) begin
            rem_in = shifted;
            quo_in = {quo_ff[26:0], 1'b0};
         end else begin
            rem_in = trial[27:0];
            quo_in = {quo_ff[26:0], 1'b1};
         end
         count_in = count_ff + 5'd1;
         if (count_ff == 5'd27) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= 5'd0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = (quo_ff[27:16] != 12'd0) ? MAX16 : quo_ff[15:0];
endmodule

### hw/rtl/awb_front.sv
// Front end: accept a transaction, latch goldens, flag zero operands, queue it.
module awb_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [0:0]          csr_index,
   input  logic [15:0]         csr_data,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [31:0]         req_tdata,
   output logic                q_valid,
   input  logic                q_pop,
   output awb_pkg::item_type   q_item
);
   import awb_pkg::*;

   localparam int unsigned Depth = 2;

   logic [15:0] golden_red_ff, golden_blue_ff;
   item_type    entry_ff [Depth];
   logic        wptr_ff, rptr_ff;
   logic [1:0]  fill_ff;
   item_type    new_item;
   logic        push;

   assign csr_ready  = 1'b1;
   assign req_tready = (fill_ff != 2'd2);
   assign push       = req_tvalid && req_tready;

   // Classify the incoming transaction.
   always_comb begin
      new_item.golden_red  = golden_red_ff;
      new_item.golden_blue = golden_blue_ff;
      new_item.meas_red    = req_tdata[15:0];
      new_item.meas_blue   = req_tdata[31:16];
      new_item.status      = (req_tdata[15:0] == 16'd0 || req_tdata[31:16] == 16'd0
                              || golden_red_ff == 16'd0 || golden_blue_ff == 16'd0)
                             ? STATUS_ZERO : STATUS_OK;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         golden_red_ff  <= 16'd0;
         golden_blue_ff <= 16'd0;
         wptr_ff        <= 1'b0;
         rptr_ff        <= 1'b0;
         fill_ff        <= 2'd0;
      end else begin
         if (csr_valid) begin
            if (csr_index == 1'b0) golden_red_ff  <= csr_data;
            else                   golden_blue_ff <= csr_data;
         end
         if (push)  wptr_ff <= ~wptr_ff;
         if (q_pop) rptr_ff <= ~rptr_ff;
         fill_ff <= fill_ff + {1'b0, push} - {1'b0, q_pop};
      end
      if (push) entry_ff[wptr_ff] <= new_item;
   end

   assign q_valid = (fill_ff != 2'd0);
   assign q_item  = entry_ff[rptr_ff];
endmodule

### hw/rtl/awb_back.sv
// Back end: sequence the divisions on one shared divider and select the gains.
module awb_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   output logic                 q_pop,
   input  awb_pkg::item_type    q_item,
   output logic                 res_valid,
   input  logic                 res_ready,
   output awb_pkg::result_type  res_data
);
   import awb_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_RATIO_R, ST_RATIO_B, ST_DIV_G, ST_DIV_H, ST_DIV_X, ST_DIV_Y, ST_OUT
   } state_type;

   state_type   state_ff;
   item_type    item_ff;
   logic [15:0] r_ff, b_ff, sr_ff, red_ff, green_ff, blue_ff;
   logic [1:0]  status_ff;
   logic        wait_ff;
   logic        div_start, div_done;
   logic [27:0] div_dividend;
   logic [16:0] div_divisor;
   logic [15:0] div_q;
   logic        red_leads;

   awb_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   assign q_pop = (state_ff == ST_IDLE) && q_valid;

   // Choose divider operands per step.
   always_comb begin
      div_dividend = 28'd0;
      div_divisor  = 17'd1;
      unique case (state_ff)
         ST_RATIO_R: begin
            div_dividend = {2'd0, item_ff.golden_red, 10'd0} + {12'd0, item_ff.meas_red};
            div_divisor  = {item_ff.meas_red, 1'b0};
         end
         ST_RATIO_B: begin
            div_dividend = {2'd0, item_ff.golden_blue, 10'd0} + {12'd0, item_ff.meas_blue};
            div_divisor  = {item_ff.meas_blue, 1'b0};
         end
         ST_DIV_G: begin
            // 131072/r for the first comparison step
            div_dividend = 28'd131072;
            div_divisor  = {1'b0, r_ff};
         end
         ST_DIV_H: begin
            // 131072/b for the second comparison step
            div_dividend = 28'd131072;
            div_divisor  = {1'b0, b_ff};
         end
         ST_DIV_X: begin
            div_dividend = 28'd131072;
            div_divisor  = {1'b0, (red_leads ? r_ff : b_ff)};
         end
         ST_DIV_Y: begin
            div_dividend = red_leads ? {4'd0, b_ff, 8'd0} : {4'd0, r_ff, 8'd0};
            div_divisor  = {1'b0, (red_leads ? r_ff : b_ff)};
         end
         default: ;
      endcase
   end

   assign div_start = !wait_ff && (state_ff == ST_RATIO_R || state_ff == ST_RATIO_B
                      || state_ff == ST_DIV_G || state_ff == ST_DIV_H
                      || state_ff == ST_DIV_X || state_ff == ST_DIV_Y);

   // r >= 512 means blue leads; b >= 512 means red leads; else compare.
   always_comb begin
      priority if (!r_ff[15] && r_ff < UNITY_RATIO && b_ff >= UNITY_RATIO)
         red_leads = 1'b1;
      else if (r_ff >= UNITY_RATIO)
         red_leads = 1'b0;
      else
         red_leads = (sr_ff >= green_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         wait_ff  <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: if (q_valid) begin
               item_ff   <= q_item;
               status_ff <= q_item.status;
               red_ff    <= 16'd0;
               green_ff  <= 16'd0;
               blue_ff   <= 16'd0;
               state_ff  <= (q_item.status == STATUS_OK) ? ST_RATIO_R : ST_OUT;
            end
            ST_RATIO_R: begin
               if (div_start) wait_ff <= 1'b1;
               else if (div_done) begin
                  wait_ff <= 1'b0;
                  r_ff <= div_q;
                  state_ff <= ST_RATIO_B;
               end
            end
            ST_RATIO_B: begin
               if (div_start) wait_ff <= 1'b1;
               else if (div_done) begin
                  wait_ff <= 1'b0;
                  b_ff <= div_q;
                  if (r_ff == 16'd0 || div_q == 16'd0) begin
                     status_ff <= STATUS_RND;
                     state_ff  <= ST_OUT;
                  end else if (r_ff >= UNITY_RATIO && div_q >= UNITY_RATIO) begin
                     red_ff   <= {1'b0, r_ff[15:1]};
                     green_ff <= UNITY_GAIN;
                     blue_ff  <= {1'b0, div_q[15:1]};
                     state_ff <= ST_OUT;
                  end else if (r_ff < UNITY_RATIO && div_q < UNITY_RATIO) begin
                     state_ff <= ST_DIV_G;
                  end else begin
                     state_ff <= ST_DIV_X;
                  end
               end
            end
            ST_DIV_G: begin
               // sr holds 131072/r
               if (div_start) wait_ff <= 1'b1;
               else if (div_done) begin
                  wait_ff  <= 1'b0;
                  sr_ff    <= div_q;
                  state_ff <= ST_DIV_H;
               end
            end
            ST_DIV_H: begin
               // green temporarily holds 131072/b for the comparison
               if (div_start) wait_ff <= 1'b1;
               else if (div_done) begin
                  wait_ff  <= 1'b0;
                  green_ff <= div_q;
                  state_ff <= ST_DIV_X;
               end
            end
            ST_DIV_X: begin
               if (div_start) wait_ff <= 1'b1;
               else if (div_done) begin
                  wait_ff  <= 1'b0;
                  green_ff <= div_q;
                  state_ff <= ST_DIV_Y;
               end
            end
            ST_DIV_Y: begin
               if (div_start) wait_ff <= 1'b1;
               else if (div_done) begin
                  wait_ff <= 1'b0;
                  if (red_leads) begin
                     red_ff  <= UNITY_GAIN;
                     blue_ff <= div_q;
                  end else begin
                     red_ff  <= div_q;
                     blue_ff <= UNITY_GAIN;
                  end
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: if (res_ready) state_ff <= ST_IDLE;
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign res_valid           = (state_ff == ST_OUT);
   assign res_data.status     = status_ff;
   assign res_data.red_gain   = red_ff;
   assign res_data.green_gain = green_ff;
   assign res_data.blue_gain  = blue_ff;
endmodule

### hw/rtl/awb_otp_gain_calc_unit.sv
// Top level of the white balance gain calculation unit.
// Each division on the shared bit-serial divider runs a start, 28 quotient bits and
// a result. An item with a zero operand runs no division; otherwise it runs two ratio
// divisions, plus two more when exactly one ratio is below unity and four more when
// both are, unless a ratio rounds to zero. The back end takes a new item only after
// the last result has been taken; a two-entry queue lets the next transaction
// be accepted while one is being computed or waits at the output.
module awb_otp_gain_calc_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // measured_red_ratio, measured_blue_ratio
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata    // status, red_gain, green_gain, blue_gain, pad
);
   import awb_pkg::*;

   item_type   q_item;
   result_type res;
   logic       q_valid, q_pop;

   awb_front u_front (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
   );

   awb_back u_back (
      .clock(clock), .reset(reset),
      .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item),
      .res_valid(rsp_tvalid), .res_ready(rsp_tready), .res_data(res)
   );

   // Pack result fields, first field lowest.
   assign rsp_tdata = {6'd0, res.blue_gain, res.green_gain, res.red_gain, res.status};
endmodule

### hw/rtl/awb_checker.sv
// Port-level checker of the white balance gain calculation unit and its bind.
`include "awb_otp_gain_calc_unit_macros.svh"
module awb_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata
);
   import awb_pkg::*;

   `AWB_ASSERT_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `AWB_ASSERT_IMPL(a_err_zero, clock, reset, rsp_tvalid && rsp_tdata[1:0] != STATUS_OK, rsp_tdata[49:2] == 48'd0)
   `AWB_ASSERT_IMPL(a_status, clock, reset, rsp_tvalid, rsp_tdata[1:0] <= STATUS_RND)
endmodule

bind awb_otp_gain_calc_unit awb_checker u_chk (
   .clock(clock), .reset(reset),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);
